>>> design/stair_climb_leg_sequencer_top_macros.svh
// assertion helpers for the sequencer top
`ifndef STAIR_CLIMB_LEG_SEQUENCER_TOP_MACROS_SVH
`define STAIR_CLIMB_LEG_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define SCL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/scl_pkg.sv
package scl_pkg;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_THRESH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_SPEED = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UP_READY_SPEED = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UP_CLOSE_SPEED = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOWN_CLOSE_SPEED = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_TOL = 3'd5;

   localparam logic [14:0] ANGLE_TOL_RESET = 15'd819;

   typedef logic signed [15:0] angle_type;

   // q3.12 radians
   localparam angle_type ANG_PI = 16'sd12868;
   localparam angle_type ANG_90 = 16'sd6434;
   localparam angle_type ANG_100 = 16'sd7149;
   localparam angle_type ANG_102 = 16'sd7292;
   localparam angle_type ANG_104 = 16'sd7435;
   localparam angle_type ANG_256 = 16'sd18301;
   localparam angle_type ANG_270 = 16'sd19302;

   // front pid output limits
   localparam logic [12:0] LIM_IDLE = 13'd5000;
   localparam logic [12:0] LIM_LIFT = 13'd2000;
   localparam logic [12:0] LIM_HIGH = 13'd7000;
   localparam logic [12:0] LIM_LOWER = 13'd600;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_READY,
      PH_STAGE2,
      PH_STAGE3,
      PH_STAGE4
   } phase_type;

   typedef enum logic [1:0] {
      REQ_UP,
      REQ_DOWN,
      REQ_NONE,
      REQ_CANCEL
   } req_type;

   typedef enum logic [1:0] {
      ACC_KEEP,
      ACC_SLOW,
      ACC_FAST
   } accel_type;

   typedef struct packed {
      logic [15:0] dist_thresh;
      logic [15:0] default_speed;
      logic [15:0] up_ready_speed;
      logic [15:0] up_close_speed;
      logic [15:0] down_close_speed;
      logic [14:0] angle_tol;
   } cfg_type;

   typedef struct packed {
      logic        start_signal;
      req_type     direction_request;
      logic [15:0] range_reading;
      logic        up_front_switch;
      logic        down_front_switch;
      logic        up_rear_switch;
      logic        down_rear_switch;
      angle_type   left_rear_measured;
      angle_type   right_rear_measured;
   } item_type;

   typedef struct packed {
      angle_type lf;
      angle_type rf;
      angle_type lr;
      angle_type rr;
   } legs_type;

   typedef struct packed {
      phase_type phase;
      logic      descending;
      legs_type  legs;
   } state_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic        descending;
      logic [15:0] speed_limit;
      accel_type   accel_code;
      logic [12:0] leg_output_limit;
      legs_type    legs;
   } result_type;

endpackage

>>> design/stair_climb_leg_sequencer_top.sv
// an accepted item is held in the input register, and its result is registered into rsp_tdata
// one item per cycle while rsp_tready is high, from the single input-to-result register step
// the input register keeps taking items while a result waits, as long as its slot drains
// reset (synchronous, active high): idle phase, climbing direction, all leg targets zero,
// registers zero except angle_tolerance = 819, both pipeline slots empty
`include "stair_climb_leg_sequencer_top_macros.svh"

module stair_climb_leg_sequencer_top (
   input  logic                            clock,
   input  logic                            reset,
   // input items
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_signal[0], direction_request[2:1], range_reading[18:3],
   // up_front_switch[19], down_front_switch[20], up_rear_switch[21],
   // down_rear_switch[22], left_rear_measured[38:23], right_rear_measured[54:39], zero pad
   input  logic [scl_pkg::REQ_DATA_W-1:0]  req_tdata,
   // result items
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // phase[2:0], descending[3], speed_limit[19:4], accel_code[21:20],
   // leg_output_limit[34:22], left_front_target[50:35], right_front_target[66:51],
   // left_rear_target[82:67], right_rear_target[98:83], zero pad
   output logic [scl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [scl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [scl_pkg::CSR_DATA_W-1:0]  csr_data
);
   import scl_pkg::*;

   cfg_type    cfg;

   // input register slot
   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   item_type   in_item_in;

   // sequencer state
   state_type  state_ff;
   state_type  state_in;
   state_type  state_next;

   // result register slot
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_data_ff;
   result_type out_data_in;
   result_type result;

   logic       fire;
   logic       req_take;

   // register writes are always taken; they take effect at the next edge,
   // so they belong between items, with nothing in flight
   assign csr_ready = 1'b1;

   scl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // one control tick: phase logic between the two register slots
   scl_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (state_next),
      .result     (result)
   );

   // the held item moves on whenever the result slot is free or being drained
   assign fire = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_take = req_tvalid && req_tready;

   // unpack the input item, lowest field first
   always_comb begin
      in_item_in = in_item_ff;
      if (req_take) begin
         in_item_in.start_signal        = req_tdata[0];
         in_item_in.direction_request   = req_type'(req_tdata[2:1]);
         in_item_in.range_reading       = req_tdata[18:3];
         in_item_in.up_front_switch     = req_tdata[19];
         in_item_in.down_front_switch   = req_tdata[20];
         in_item_in.up_rear_switch      = req_tdata[21];
         in_item_in.down_rear_switch    = req_tdata[22];
         in_item_in.left_rear_measured  = req_tdata[38:23];
         in_item_in.right_rear_measured = req_tdata[54:39];
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // state and result advance together, once per item
   always_comb begin
      state_in = fire ? state_next : state_ff;
      out_data_in = fire ? result : out_data_ff;
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= '{phase: PH_IDLE, descending: 1'b0, legs: '0};
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff <= state_in;
      end
   end

   // payload slots need no reset
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {5'b00000,
                       out_data_ff.legs.rr,
                       out_data_ff.legs.lr,
                       out_data_ff.legs.rf,
                       out_data_ff.legs.lf,
                       out_data_ff.leg_output_limit,
                       out_data_ff.accel_code,
                       out_data_ff.speed_limit,
                       out_data_ff.descending,
                       out_data_ff.phase};

   // a stalled item stays in the input slot untouched
   `SCL_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !fire, in_valid_ff && $stable(in_item_ff), "stalled input item changed")
   // every tick that runs presents its result
   `SCL_ASSERT_NEXT(a_rsp_load, clock, reset, fire, rsp_tvalid, "result not presented after tick")
   // no item, no state change
   `SCL_ASSERT_NEXT(a_state_hold, clock, reset, !fire, $stable(state_ff), "state moved without an item")
   // direction only latches in idle
   `SCL_ASSERT_NEXT(a_dir_lock, clock, reset, fire && (state_ff.phase != PH_IDLE), $stable(state_ff.descending), "direction changed outside idle")

endmodule

>>> design/scl_csr.sv
module scl_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [scl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [scl_pkg::CSR_DATA_W-1:0]  csr_data,
   output scl_pkg::cfg_type                cfg
);
   import scl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DIST_THRESH:      cfg_in.dist_thresh = csr_data;
            CSR_DEFAULT_SPEED:    cfg_in.default_speed = csr_data;
            CSR_UP_READY_SPEED:   cfg_in.up_ready_speed = csr_data;
            CSR_UP_CLOSE_SPEED:   cfg_in.up_close_speed = csr_data;
            CSR_DOWN_CLOSE_SPEED: cfg_in.down_close_speed = csr_data;
            CSR_ANGLE_TOL:        cfg_in.angle_tol = csr_data[14:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{dist_thresh: '0, default_speed: '0, up_ready_speed: '0,
                     up_close_speed: '0, down_close_speed: '0,
                     angle_tol: ANGLE_TOL_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/scl_step.sv
module scl_step (
   input  scl_pkg::cfg_type    cfg,
   input  scl_pkg::state_type  state,
   input  scl_pkg::item_type   item,
   output scl_pkg::state_type  state_next,
   output scl_pkg::result_type result
);
   import scl_pkg::*;

   phase_type   phase_eff;
   logic        dir_eff;
   phase_type   phase_next;
   logic signed [17:0] lr_err;
   logic signed [17:0] rr_err;
   logic signed [17:0] lr_abs;
   logic signed [17:0] rr_abs;
   logic        lift_done;
   logic [15:0] speed;
   accel_type   accel;
   logic [12:0] limit;
   legs_type    legs;

   // direction latch while idle, then cancel out of ready
   always_comb begin
      dir_eff = state.descending;
      if (state.phase == PH_IDLE) begin
         if (item.direction_request == REQ_UP) begin
            dir_eff = 1'b0;
         end else if (item.direction_request == REQ_DOWN) begin
            dir_eff = 1'b1;
         end
      end
      phase_eff = state.phase;
      if (item.direction_request == REQ_CANCEL && state.phase == PH_READY) begin
         phase_eff = PH_IDLE;
      end
   end

   // rear legs near -pi (left) and +pi (right)
   always_comb begin
      lr_err = 18'(item.left_rear_measured) + 18'(ANG_PI);
      rr_err = 18'(item.right_rear_measured) - 18'(ANG_PI);
      lr_abs = lr_err[17] ? -lr_err : lr_err;
      rr_abs = rr_err[17] ? -rr_err : rr_err;
      lift_done = !item.up_front_switch
                  && (lr_abs < 18'({3'b000, cfg.angle_tol}))
                  && (rr_abs < 18'({3'b000, cfg.angle_tol}));
   end

   // next phase
   always_comb begin
      phase_next = phase_eff;
      case (phase_eff)
         PH_IDLE: begin
            if (item.start_signal) phase_next = PH_READY;
         end
         PH_READY: begin
            if (dir_eff) begin
               if (item.down_rear_switch) phase_next = PH_STAGE2;
            end else begin
               if (item.range_reading < cfg.dist_thresh) phase_next = PH_STAGE2;
            end
         end
         PH_STAGE2: begin
            if (dir_eff) begin
               if (item.down_front_switch) phase_next = PH_STAGE3;
            end else begin
               if (lift_done) phase_next = PH_STAGE3;
            end
         end
         PH_STAGE3: begin
            if (dir_eff) begin
               if (item.start_signal) phase_next = PH_STAGE4;
            end else begin
               if (!item.up_rear_switch) phase_next = PH_STAGE4;
            end
         end
         PH_STAGE4: begin
            if (item.start_signal) phase_next = PH_IDLE;
         end
         default: phase_next = PH_IDLE;
      endcase
   end

   // per-phase outputs and leg targets
   always_comb begin
      speed = cfg.default_speed;
      accel = ACC_KEEP;
      limit = LIM_IDLE;
      legs = state.legs;
      case (phase_eff)
         PH_IDLE: begin
            legs = '0;
         end
         PH_READY: begin
            if (dir_eff) begin
               speed = cfg.down_close_speed;
               legs = '{lf: ANG_90, rf: ANG_270, lr: -ANG_90, rr: ANG_90};
            end else begin
               speed = cfg.up_ready_speed;
               legs = '{lf: ANG_256, rf: ANG_104, lr: -ANG_102, rr: ANG_102};
            end
         end
         PH_STAGE2: begin
            if (dir_eff) begin
               speed = cfg.down_close_speed;
               limit = LIM_HIGH;
               legs.lr = -ANG_PI;
               legs.rr = ANG_PI;
            end else begin
               speed = cfg.up_close_speed;
               accel = ACC_SLOW;
               limit = LIM_LIFT;
               legs = '{lf: ANG_PI, rf: ANG_PI, lr: -ANG_PI, rr: ANG_PI};
            end
         end
         PH_STAGE3: begin
            limit = LIM_HIGH;
            if (dir_eff) begin
               speed = cfg.down_close_speed;
               legs.lf = ANG_PI;
               legs.rf = ANG_PI;
            end else begin
               speed = cfg.up_close_speed;
               accel = ACC_FAST;
               legs.lf = ANG_90;
               legs.rf = ANG_270;
            end
         end
         PH_STAGE4: begin
            if (dir_eff) begin
               speed = cfg.down_close_speed;
               limit = LIM_LOWER;
               legs = '{lf: ANG_256, rf: ANG_104, lr: -ANG_100, rr: ANG_100};
            end else begin
               speed = cfg.up_close_speed;
               limit = LIM_HIGH;
               legs.lr = '0;
               legs.rr = '0;
            end
         end
         default: begin
            legs = state.legs;
         end
      endcase
   end

   assign state_next = '{phase: phase_next, descending: dir_eff, legs: legs};
   assign result = '{phase: phase_next, descending: dir_eff, speed_limit: speed,
                     accel_code: accel, leg_output_limit: limit, legs: legs};

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import scl_pkg::*;

   localparam int SEG_ITEMS = 135;       // random items per register setting
   localparam int HOLD_CYCLES = 60;      // one long receiver hold-off
   localparam int DRAIN_CYCLES = 4;      // margin after the last result returns
   localparam int RUN_LIMIT_NS = 4_000_000;
   localparam int MAX_PRINTED = 100;

   // register values used by the directed part
   localparam logic [15:0] CFG_THRESH = 16'd1000;
   localparam logic [15:0] CFG_DEFAULT = 16'h0180;
   localparam logic [15:0] CFG_UP_READY = 16'h0240;
   localparam logic [15:0] CFG_UP_CLOSE = 16'h0300;
   localparam logic [15:0] CFG_DOWN_CLOSE = 16'h0420;
   localparam angle_type ZERO_ANG = 16'sd0;

   typedef struct {
      item_type   it;
      bit         typed;
      result_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state: registers, phase, direction and held leg targets
   cfg_type tb_cfg;
   phase_type seq_phase;
   logic seq_down;
   legs_type seq_legs;

   result_type expected_results[$];
   directed_row_type directed_rows[$];

   int error_count = 0;
   int results_checked = 0;
   int items_sent = 0;
   int settings_used = 0;
   logic [15:0] states_seen = '0;

   // flags from the stimulus process to the receiver
   logic rx_idle_on = 1'b0;
   logic hold_armed = 1'b0;
   int hold_count = 0;
   int rx_gap = 0;
   bit tx_idle_on;

   stair_climb_leg_sequencer_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // run limit, far beyond the slowest correct run
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout: %0d results still outstanding", expected_results.size());
      $display("** stair_climb_leg_sequencer_top: FAILED **");
      $finish;
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   function automatic legs_type leg_set(input angle_type lf, input angle_type rf,
                                        input angle_type lr, input angle_type rr);
      legs_type l;
      l.lf = lf;
      l.rf = rf;
      l.lr = lr;
      l.rr = rr;
      return l;
   endfunction

   // one control tick of the sequencer: updates the predictor state and
   // returns the result item the block should emit for it
   function automatic result_type climb_step(input item_type it);
      result_type r;
      logic [15:0] spd;
      accel_type acc;
      logic [12:0] lim;
      int lr_err;
      int rr_err;
      spd = tb_cfg.default_speed;
      acc = ACC_KEEP;
      lim = LIM_IDLE;
      // rear errors in wide arithmetic, no wrap at the 16-bit edges
      lr_err = int'(it.left_rear_measured) + int'(ANG_PI);
      rr_err = int'(it.right_rear_measured) - int'(ANG_PI);
      if (lr_err < 0) lr_err = -lr_err;
      if (rr_err < 0) rr_err = -rr_err;

      // direction latches only while idle, cancel only from ready
      if (seq_phase == PH_IDLE) begin
         if (it.direction_request == REQ_UP) seq_down = 1'b0;
         else if (it.direction_request == REQ_DOWN) seq_down = 1'b1;
      end
      if (it.direction_request == REQ_CANCEL && seq_phase == PH_READY) seq_phase = PH_IDLE;

      if (seq_phase == PH_IDLE) begin
         seq_legs = leg_set(ZERO_ANG, ZERO_ANG, ZERO_ANG, ZERO_ANG);
         if (it.start_signal) seq_phase = PH_READY;
      end else if (!seq_down) begin
         case (seq_phase)
            PH_READY: begin
               spd = tb_cfg.up_ready_speed;
               seq_legs = leg_set(ANG_256, ANG_104, -ANG_102, ANG_102);
               if (it.range_reading < tb_cfg.dist_thresh) seq_phase = PH_STAGE2;
            end
            PH_STAGE2: begin
               // lift: every leg to pi, the left rear to -pi
               spd = tb_cfg.up_close_speed;
               acc = ACC_SLOW;
               lim = LIM_LIFT;
               seq_legs = leg_set(ANG_PI, ANG_PI, -ANG_PI, ANG_PI);
               if (!it.up_front_switch && lr_err < int'(tb_cfg.angle_tol)
                   && rr_err < int'(tb_cfg.angle_tol)) seq_phase = PH_STAGE3;
            end
            PH_STAGE3: begin
               // front retract
               spd = tb_cfg.up_close_speed;
               acc = ACC_FAST;
               lim = LIM_HIGH;
               seq_legs.lf = ANG_90;
               seq_legs.rf = ANG_270;
               if (!it.up_rear_switch) seq_phase = PH_STAGE4;
            end
            PH_STAGE4: begin
               // rear retract
               spd = tb_cfg.up_close_speed;
               lim = LIM_HIGH;
               seq_legs.lr = ZERO_ANG;
               seq_legs.rr = ZERO_ANG;
               if (it.start_signal) seq_phase = PH_IDLE;
            end
            default: seq_phase = PH_IDLE;
         endcase
      end else begin
         case (seq_phase)
            PH_READY: begin
               spd = tb_cfg.down_close_speed;
               seq_legs = leg_set(ANG_90, ANG_270, -ANG_90, ANG_90);
               if (it.down_rear_switch) seq_phase = PH_STAGE2;
            end
            PH_STAGE2: begin
               // rear extend
               spd = tb_cfg.down_close_speed;
               lim = LIM_HIGH;
               seq_legs.lr = -ANG_PI;
               seq_legs.rr = ANG_PI;
               if (it.down_front_switch) seq_phase = PH_STAGE3;
            end
            PH_STAGE3: begin
               // front extend
               spd = tb_cfg.down_close_speed;
               lim = LIM_HIGH;
               seq_legs.lf = ANG_PI;
               seq_legs.rf = ANG_PI;
               if (it.start_signal) seq_phase = PH_STAGE4;
            end
            PH_STAGE4: begin
               // lower onto the step
               spd = tb_cfg.down_close_speed;
               lim = LIM_LOWER;
               seq_legs = leg_set(ANG_256, ANG_104, -ANG_100, ANG_100);
               if (it.start_signal) seq_phase = PH_IDLE;
            end
            default: seq_phase = PH_IDLE;
         endcase
      end

      r.phase = seq_phase;
      r.descending = seq_down;
      r.speed_limit = spd;
      r.accel_code = acc;
      r.leg_output_limit = lim;
      r.legs = seq_legs;
      return r;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_item(input item_type it);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[0] = it.start_signal;
      d[2:1] = it.direction_request;
      d[18:3] = it.range_reading;
      d[19] = it.up_front_switch;
      d[20] = it.down_front_switch;
      d[21] = it.up_rear_switch;
      d[22] = it.down_rear_switch;
      d[38:23] = it.left_rear_measured;
      d[54:39] = it.right_rear_measured;
      return d;
   endfunction

   function automatic result_type unpack_rsp(input logic [RSP_DATA_W-1:0] d);
      result_type r;
      r.phase = d[2:0];
      r.descending = d[3];
      r.speed_limit = d[19:4];
      r.accel_code = accel_type'(d[21:20]);
      r.leg_output_limit = d[34:22];
      r.legs.lf = d[50:35];
      r.legs.rf = d[66:51];
      r.legs.lr = d[82:67];
      r.legs.rr = d[98:83];
      return r;
   endfunction

   // sw is {down_rear, up_rear, down_front, up_front}
   function automatic item_type stim(input bit sig, input req_type rq, input logic [15:0] range_val,
                                     input logic [3:0] sw, input angle_type lrm,
                                     input angle_type rrm);
      item_type it;
      it.start_signal = sig;
      it.direction_request = rq;
      it.range_reading = range_val;
      it.up_front_switch = sw[0];
      it.down_front_switch = sw[1];
      it.up_rear_switch = sw[2];
      it.down_rear_switch = sw[3];
      it.left_rear_measured = lrm;
      it.right_rear_measured = rrm;
      return it;
   endfunction

   function automatic result_type want(input phase_type ph, input bit desc,
                                       input logic [15:0] spd, input accel_type acc,
                                       input logic [12:0] lim, input legs_type lg);
      result_type r;
      r.phase = ph;
      r.descending = desc;
      r.speed_limit = spd;
      r.accel_code = acc;
      r.leg_output_limit = lim;
      r.legs = lg;
      return r;
   endfunction

   function automatic angle_type clamp_angle(input int v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   // random tick, mostly steered toward the condition that leaves the
   // current phase so that whole climbs and descents run through
   function automatic item_type random_climb_item();
      item_type it;
      logic [31:0] r1, r2, r3, rv;
      int pick, tol, off;
      r1 = $urandom;
      r2 = $urandom;
      r3 = $urandom;
      it.start_signal = r1[0];
      it.direction_request = req_type'(r1[2:1]);
      it.up_front_switch = r1[3];
      it.down_front_switch = r1[4];
      it.up_rear_switch = r1[5];
      it.down_rear_switch = r1[6];
      it.range_reading = r1[31:16];
      it.left_rear_measured = r2[15:0];
      it.right_rear_measured = r2[31:16];
      tol = int'(tb_cfg.angle_tol);
      pick = $urandom_range(0, 99);

      if (pick < 65) begin
         // turn half of the cancels away from ready so the deep phases are reached
         if (it.direction_request == REQ_CANCEL && r3[2]) it.direction_request = REQ_NONE;
         case (seq_phase)
            PH_IDLE: begin
               it.start_signal = 1'b1;
               it.direction_request = r3[0] ? REQ_DOWN : REQ_UP;
            end
            PH_READY: begin
               if (seq_down) begin
                  it.down_rear_switch = 1'b1;
               end else if (tb_cfg.dist_thresh != 16'd0) begin
                  rv = $urandom_range(0, int'(tb_cfg.dist_thresh) - 1);
                  it.range_reading = rv[15:0];
               end
            end
            PH_STAGE2: begin
               if (seq_down) begin
                  it.down_front_switch = 1'b1;
               end else begin
                  it.up_front_switch = 1'b0;
                  off = 0;
                  if (tol > 0) begin
                     rv = $urandom_range(0, 2 * tol - 2);
                     off = int'(rv) - (tol - 1);
                  end
                  it.left_rear_measured = clamp_angle(off - int'(ANG_PI));
                  if (tol > 0) begin
                     rv = $urandom_range(0, 2 * tol - 2);
                     off = int'(rv) - (tol - 1);
                  end
                  it.right_rear_measured = clamp_angle(off + int'(ANG_PI));
               end
            end
            PH_STAGE3: begin
               if (seq_down) it.start_signal = 1'b1;
               else it.up_rear_switch = 1'b0;
            end
            PH_STAGE4: it.start_signal = 1'b1;
            default: ;
         endcase
      end else if (pick < 80 && !seq_down) begin
         // land exactly on the compare boundaries
         if (seq_phase == PH_READY) begin
            it.range_reading = tb_cfg.dist_thresh;
         end else if (seq_phase == PH_STAGE2) begin
            it.up_front_switch = 1'b0;
            it.left_rear_measured = clamp_angle((r3[5] ? tol : -tol) - int'(ANG_PI));
            it.right_rear_measured = clamp_angle((r3[6] ? tol : -tol) + int'(ANG_PI));
         end
      end
      return it;
   endfunction

   // offer one item, with an optional gap first, and predict it on acceptance
   task automatic send_item(input item_type it, input bit typed, input result_type typed_res);
      result_type r;
      int gap;
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pack_item(it);
      do @(posedge clock); while (!req_tready);
      r = climb_step(it);
      expected_results.push_back(typed ? typed_res : r);
      items_sent++;
   endtask

   // stop offering and wait until every predicted item has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DIST_THRESH: tb_cfg.dist_thresh = val;
         CSR_DEFAULT_SPEED: tb_cfg.default_speed = val;
         CSR_UP_READY_SPEED: tb_cfg.up_ready_speed = val;
         CSR_UP_CLOSE_SPEED: tb_cfg.up_close_speed = val;
         CSR_DOWN_CLOSE_SPEED: tb_cfg.down_close_speed = val;
         CSR_ANGLE_TOL: tb_cfg.angle_tol = val[14:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [15:0] thresh, input logic [15:0] dflt,
                               input logic [15:0] up_ready, input logic [15:0] up_close,
                               input logic [15:0] down_close, input logic [15:0] tol);
      write_reg(CSR_DIST_THRESH, thresh);
      write_reg(CSR_DEFAULT_SPEED, dflt);
      write_reg(CSR_UP_READY_SPEED, up_ready);
      write_reg(CSR_UP_CLOSE_SPEED, up_close);
      write_reg(CSR_DOWN_CLOSE_SPEED, down_close);
      write_reg(CSR_ANGLE_TOL, tol);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic add_row(input item_type it, input bit typed, input result_type w);
      directed_row_type row;
      row.it = it;
      row.typed = typed;
      row.want = w;
      directed_rows.push_back(row);
   endtask

   task automatic walk_rows(input int first, input int last);
      for (int i = first; i <= last; i++) begin
         send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
      end
   endtask

   // compare one result item against the oldest prediction
   task automatic check_result(input result_type got);
      result_type w;
      if (expected_results.size() == 0) begin
         report_error($sformatf("result item %0d arrived with nothing expected", results_checked));
      end else begin
         w = expected_results.pop_front();
         states_seen[{w.descending, w.phase}] = 1'b1;
         if (got.phase !== w.phase)
            report_error($sformatf("item %0d phase got %0d want %0d",
                                   results_checked, got.phase, w.phase));
         if (got.descending !== w.descending)
            report_error($sformatf("item %0d descending got %0d want %0d",
                                   results_checked, got.descending, w.descending));
         if (got.speed_limit !== w.speed_limit)
            report_error($sformatf("item %0d speed_limit got %h want %h",
                                   results_checked, got.speed_limit, w.speed_limit));
         if (got.accel_code !== w.accel_code)
            report_error($sformatf("item %0d accel_code got %0d want %0d",
                                   results_checked, got.accel_code, w.accel_code));
         if (got.leg_output_limit !== w.leg_output_limit)
            report_error($sformatf("item %0d leg_output_limit got %0d want %0d",
                                   results_checked, got.leg_output_limit, w.leg_output_limit));
         if (got.legs.lf !== w.legs.lf)
            report_error($sformatf("item %0d left_front_target got %0d want %0d",
                                   results_checked, got.legs.lf, w.legs.lf));
         if (got.legs.rf !== w.legs.rf)
            report_error($sformatf("item %0d right_front_target got %0d want %0d",
                                   results_checked, got.legs.rf, w.legs.rf));
         if (got.legs.lr !== w.legs.lr)
            report_error($sformatf("item %0d left_rear_target got %0d want %0d",
                                   results_checked, got.legs.lr, w.legs.lr));
         if (got.legs.rr !== w.legs.rr)
            report_error($sformatf("item %0d right_rear_target got %0d want %0d",
                                   results_checked, got.legs.rr, w.legs.rr));
      end
      results_checked++;
   endtask

   // result side: random stall bursts, one long hold-off, and the checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_armed && hold_count < HOLD_CYCLES) begin
         // long hold-off so both pipeline slots fill and req_tready drops
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
      end else if (rx_gap > 0) begin
         rsp_tready <= 1'b0;
         rx_gap <= rx_gap - 1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         rx_gap <= int'($urandom_range(0, 3));
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result(unpack_rsp(rsp_tdata));
   end

   initial begin
      logic [31:0] ra, rb, rc;
      int directed_count;

      // predictor starts in the reset state
      tb_cfg.dist_thresh = '0;
      tb_cfg.default_speed = '0;
      tb_cfg.up_ready_speed = '0;
      tb_cfg.up_close_speed = '0;
      tb_cfg.down_close_speed = '0;
      tb_cfg.angle_tol = ANGLE_TOL_RESET;
      seq_phase = PH_IDLE;
      seq_down = 1'b0;
      seq_legs = '0;
      tx_idle_on = 1'b1;

      // directed rows; the first two run with the reset register values
      // idle after reset, nothing set yet
      add_row(stim(1'b0, REQ_NONE, 16'd0, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b1,
              want(PH_IDLE, 1'b0, 16'd0, ACC_KEEP, LIM_IDLE,
                   leg_set(ZERO_ANG, ZERO_ANG, ZERO_ANG, ZERO_ANG)));
      // all fields at their top or bottom, signal enters ready
      add_row(stim(1'b1, REQ_UP, 16'hFFFF, 4'b1111, 16'sh8000, 16'sh7FFF), 1'b1,
              want(PH_READY, 1'b0, 16'd0, ACC_KEEP, LIM_IDLE,
                   leg_set(ZERO_ANG, ZERO_ANG, ZERO_ANG, ZERO_ANG)));
      // range equal to the threshold does not advance
      add_row(stim(1'b0, REQ_NONE, CFG_THRESH, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b1,
              want(PH_READY, 1'b0, CFG_UP_READY, ACC_KEEP, LIM_IDLE,
                   leg_set(ANG_256, ANG_104, -ANG_102, ANG_102)));
      // cancel with the signal high re-enters ready in the same tick
      add_row(stim(1'b1, REQ_CANCEL, 16'd0, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b0, REQ_CANCEL, 16'hFFFF, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      // direction changes in idle without the signal
      add_row(stim(1'b0, REQ_DOWN, 16'd0, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b1, REQ_UP, 16'd0, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b0, REQ_NONE, CFG_THRESH - 16'd1, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      // lift: left rear exactly on the tolerance edge stays
      add_row(stim(1'b0, REQ_NONE, 16'd0, 4'b1110, -ANG_PI + 16'sd819, ANG_PI), 1'b0, '0);
      // lift: far measurements must not wrap into range; cancel ignored
      add_row(stim(1'b1, REQ_CANCEL, 16'd0, 4'b0000, 16'sh7FFF, 16'sh8000), 1'b0, '0);
      // lift: switch still set
      add_row(stim(1'b0, REQ_NONE, 16'd0, 4'b0001, -ANG_PI, ANG_PI), 1'b0, '0);
      // lift: just inside tolerance on both sides
      add_row(stim(1'b0, REQ_NONE, 16'd0, 4'b0100, -ANG_PI - 16'sd818, ANG_PI + 16'sd818),
              1'b0, '0);
      // front retract waits for the rear switch, down request ignored
      add_row(stim(1'b1, REQ_DOWN, 16'd0, 4'b0100, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b0, REQ_NONE, 16'd0, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b0, REQ_UP, 16'd0, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b1, REQ_NONE, 16'd0, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      // descending path
      add_row(stim(1'b1, REQ_DOWN, 16'd0, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b0, REQ_NONE, 16'd0, 4'b0111, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b0, REQ_CANCEL, 16'd0, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b1, REQ_DOWN, 16'd0, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b0, REQ_NONE, 16'd0, 4'b1000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b0, REQ_CANCEL, 16'd0, 4'b1101, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b0, REQ_NONE, 16'd0, 4'b0010, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b0, REQ_NONE, 16'd0, 4'b1111, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b1, REQ_NONE, 16'd0, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b0, REQ_UP, 16'd0, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      add_row(stim(1'b1, REQ_NONE, 16'd0, 4'b0000, ZERO_ANG, ZERO_ANG), 1'b0, '0);
      directed_count = directed_rows.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      rx_idle_on <= 1'b1;
      @(posedge clock);

      // reset register values first, then the directed setting
      walk_rows(0, 1);
      wait_drained();
      program_regs(CFG_THRESH, CFG_DEFAULT, CFG_UP_READY, CFG_UP_CLOSE, CFG_DOWN_CLOSE,
                   {1'b0, ANGLE_TOL_RESET});
      walk_rows(2, directed_count - 1);

      // random part: one block of items per register setting
      for (int s = 0; s < 5; s++) begin
         wait_drained();
         ra = $urandom;
         rb = $urandom;
         rc = $urandom;
         case (s)
            0: hold_armed <= 1'b1;   // keep the directed setting, add the long hold-off
            1: program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: program_regs(ra[15:0], ra[31:16], rb[15:0], rb[31:16], rc[15:0], rc[31:16]);
            default: begin
               rc = $urandom_range(1, 3000);
               program_regs(ra[15:0], ra[31:16], rb[15:0], rb[31:16], ra[23:8], rc[15:0]);
            end
         endcase
         // the last block runs with both sides at full rate
         if (s == 4) begin
            tx_idle_on = 1'b0;
            rx_idle_on <= 1'b0;
         end
         for (int n = 0; n < SEG_ITEMS; n++) begin
            // one pause in the middle until everything has come back
            if (s == 0 && n == SEG_ITEMS / 2) wait_drained();
            send_item(random_climb_item(), 1'b0, '0);
         end
      end

      wait_drained();
      $display("sent %0d items (%0d directed), checked %0d results, %0d register settings",
               items_sent, directed_count, results_checked, settings_used);
      $display("reached %0d of 10 direction and phase combinations, %0d mismatches",
               $countones(states_seen), error_count);
      if (error_count == 0) begin
         $display("** stair_climb_leg_sequencer_top: PASSED **");
      end else begin
         $display("** stair_climb_leg_sequencer_top: FAILED **");
      end
      $finish;
   end

endmodule
